/* hw/rtl/iss_pkg.sv */
// ----------------------------------------------------------------------------
// iss_pkg
// Shared types and timing constants for the intersection signal sequencer.
// ----------------------------------------------------------------------------
package iss_pkg;

  localparam int unsigned SecW   = 5;
  localparam int unsigned CfgIdxW = 1;

  typedef logic [SecW-1:0] secs_t;

  // Lamp color codes as driven on the color ports.
  typedef enum logic [1:0] {
    COLOR_OFF    = 2'd0,
    COLOR_RED    = 2'd1,
    COLOR_GREEN  = 2'd2,
    COLOR_YELLOW = 2'd3
  } color_t;

  // Phases of one signal cycle, plus the all-red flashing mode.
  typedef enum logic [3:0] {
    PH_START   = 4'd0,
    PH_NS_PED  = 4'd1,
    PH_NS_G    = 4'd2,
    PH_NS_Y    = 4'd3,
    PH_EWLT_G  = 4'd4,
    PH_EWLT_Y  = 4'd5,
    PH_EW_PED  = 4'd6,
    PH_EW_G    = 4'd7,
    PH_EW_Y    = 4'd8,
    PH_NSLT_G  = 4'd9,
    PH_NSLT_Y  = 4'd10,
    PH_FLASH   = 4'd11
  } phase_t;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_NS_WALK = 1'd0,
    CFG_EW_WALK = 1'd1
  } cfg_idx_t;

  localparam secs_t WalkSecsReset = secs_t'(8);

  // Phase lengths in seconds.
  localparam secs_t TNsGreenDay    = secs_t'(7);
  localparam secs_t TNsGreenNight  = secs_t'(6);
  localparam secs_t TEwTurnDay     = secs_t'(8);
  localparam secs_t TEwTurnNight   = secs_t'(7);
  localparam secs_t TEwGreen       = secs_t'(6);
  localparam secs_t TNsTurnDay     = secs_t'(7);
  localparam secs_t TNsTurnNight   = secs_t'(8);
  localparam secs_t TYellow        = secs_t'(3);

  // Sequencer state carried from one tick to the next.
  typedef struct packed {
    phase_t phase;
    secs_t  secs;
    logic   night;
    logic   ns_walk;
    logic   ew_walk;
    logic   flash_pending;
    logic   flash_lit;
  } seq_state_t;

  // One tick's lamp and display outputs.
  typedef struct packed {
    color_t ns_color;
    color_t ns_turn_color;
    color_t ew_color;
    color_t ew_turn_color;
    secs_t  seconds_left;
    logic   beep;
    logic   flashing;
  } seq_result_t;

endpackage

/* hw/rtl/intersection_signal_sequencer.sv */
// ----------------------------------------------------------------------------
// intersection_signal_sequencer
// Four-signal intersection sequencer advanced by one-second tick words.
// ----------------------------------------------------------------------------
// Each input word is one second of time: it carries the daylight level, the
// two left-turn sensor levels and the pedestrian and flash button presses of
// that second, and produces exactly one output word with the four lamp colors,
// the countdown value, the buzzer and the flashing flag. A cycle runs north-
// south green and yellow, an optional east-west left turn, east-west green and
// yellow and an optional north-south left turn; in day timing a latched
// pedestrian request inserts a beeping walk countdown (length set by the two
// configuration registers) ahead of the matching green. A flash request, taken
// at the end of a cycle, blinks all reds until a second request. The whole
// tick update is one level of logic between the state registers and the
// output register, so a word is accepted in every clock cycle and its result
// appears in the next cycle; the output register decouples the two sides, and
// in_ready only drops while a result is held by a stalled consumer.
// Configuration writes take effect immediately and are meant to happen while
// no word is in flight.
// ----------------------------------------------------------------------------
module intersection_signal_sequencer
  import iss_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,

  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [SecW-1:0]    cfg_wdata,

  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_daylight,
  input  logic               in_ns_walk_press,
  input  logic               in_ew_walk_press,
  input  logic               in_ns_turn_waiting,
  input  logic               in_ew_turn_waiting,
  input  logic               in_flash_press,

  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_ns_color,
  output logic [1:0]         out_ns_turn_color,
  output logic [1:0]         out_ew_color,
  output logic [1:0]         out_ew_turn_color,
  output logic [SecW-1:0]    out_seconds_left,
  output logic               out_beep,
  output logic               out_flashing
);

  localparam seq_state_t StateReset = '{
    phase:         PH_START,
    secs:          '0,
    night:         1'b0,
    ns_walk:       1'b0,
    ew_walk:       1'b0,
    flash_pending: 1'b0,
    flash_lit:     1'b1
  };

  secs_t       ns_walk_secs_r;
  secs_t       ew_walk_secs_r;
  seq_state_t  state_r;
  seq_state_t  state_nxt;
  seq_result_t result_nxt;
  seq_result_t result_r;
  logic        out_valid_r;
  logic        in_fire;

  // The output register is free when empty or being drained this cycle.
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Configuration registers; an index with no register behind it is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ns_walk_secs_r <= WalkSecsReset;
      ew_walk_secs_r <= WalkSecsReset;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_NS_WALK: ns_walk_secs_r <= cfg_wdata;
        CFG_EW_WALK: ew_walk_secs_r <= cfg_wdata;
        default:     ;
      endcase
    end
  end

  iss_step u_step (
    .state           (state_r),
    .daylight        (in_daylight),
    .ns_walk_press   (in_ns_walk_press),
    .ew_walk_press   (in_ew_walk_press),
    .ns_turn_waiting (in_ns_turn_waiting),
    .ew_turn_waiting (in_ew_turn_waiting),
    .flash_press     (in_flash_press),
    .ns_walk_secs    (ns_walk_secs_r),
    .ew_walk_secs    (ew_walk_secs_r),
    .state_nxt       (state_nxt),
    .result          (result_nxt)
  );

  // Sequencer state moves one tick per accepted word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= StateReset;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // The result payload needs no reset; it is qualified by out_valid.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_ns_color      = result_r.ns_color;
  assign out_ns_turn_color = result_r.ns_turn_color;
  assign out_ew_color      = result_r.ew_color;
  assign out_ew_turn_color = result_r.ew_turn_color;
  assign out_seconds_left  = result_r.seconds_left;
  assign out_beep          = result_r.beep;
  assign out_flashing      = result_r.flashing;

endmodule

/* hw/rtl/iss_step.sv */
// ----------------------------------------------------------------------------
// iss_step
// Combinational next-state and output logic for one one-second tick.
// ----------------------------------------------------------------------------
module iss_step
  import iss_pkg::*;
(
  input  seq_state_t  state,
  input  logic        daylight,
  input  logic        ns_walk_press,
  input  logic        ew_walk_press,
  input  logic        ns_turn_waiting,
  input  logic        ew_turn_waiting,
  input  logic        flash_press,
  input  secs_t       ns_walk_secs,
  input  secs_t       ew_walk_secs,
  output seq_state_t  state_nxt,
  output seq_result_t result
);

  function automatic seq_state_t enter_phase(seq_state_t s, phase_t p, secs_t n);
    seq_state_t r;
    r       = s;
    r.phase = p;
    r.secs  = n;
    return r;
  endfunction

  function automatic seq_state_t start_cycle(seq_state_t s, logic day, secs_t walk);
    seq_state_t r;
    r       = s;
    r.night = !day;
    if (r.night) begin
      r.ns_walk = 1'b0;
      r.ew_walk = 1'b0;
    end
    if (!r.night && r.ns_walk && (walk != '0)) begin
      r = enter_phase(r, PH_NS_PED, walk);
    end else begin
      if (!r.night) begin
        r.ns_walk = 1'b0;
      end
      r = enter_phase(r, PH_NS_G, r.night ? TNsGreenNight : TNsGreenDay);
    end
    return r;
  endfunction

  function automatic seq_state_t ew_branch(seq_state_t s, secs_t walk);
    seq_state_t r;
    r = s;
    if (!r.night && r.ew_walk && (walk != '0)) begin
      r = enter_phase(r, PH_EW_PED, walk);
    end else begin
      if (!r.night) begin
        r.ew_walk = 1'b0;
      end
      r = enter_phase(r, PH_EW_G, TEwGreen);
    end
    return r;
  endfunction

  function automatic seq_state_t cycle_end(seq_state_t s, logic day, secs_t walk);
    seq_state_t r;
    r = s;
    if (r.flash_pending) begin
      r.flash_pending = 1'b0;
      r.flash_lit     = 1'b1;
      r               = enter_phase(r, PH_FLASH, '0);
    end else begin
      r = start_cycle(r, day, walk);
    end
    return r;
  endfunction

  always_comb begin
    seq_state_t  s;
    seq_result_t o;
    color_t      c;

    s = state;

    // Leaving flash mode only at the start of a lit second.
    if (s.phase == PH_FLASH && s.flash_lit && s.flash_pending) begin
      s.flash_pending = 1'b0;
      s = enter_phase(s, PH_START, '0);
    end

    if (s.phase != PH_FLASH && s.secs == '0) begin
      case (s.phase)
        PH_NS_PED: begin
          s.ns_walk = 1'b0;
          s = enter_phase(s, PH_NS_G, s.night ? TNsGreenNight : TNsGreenDay);
        end
        PH_NS_G:   s = enter_phase(s, PH_NS_Y, TYellow);
        PH_NS_Y: begin
          if (ew_turn_waiting) begin
            s = enter_phase(s, PH_EWLT_G, s.night ? TEwTurnNight : TEwTurnDay);
          end else begin
            s = ew_branch(s, ew_walk_secs);
          end
        end
        PH_EWLT_G: s = enter_phase(s, PH_EWLT_Y, TYellow);
        PH_EWLT_Y: s = ew_branch(s, ew_walk_secs);
        PH_EW_PED: begin
          s.ew_walk = 1'b0;
          s = enter_phase(s, PH_EW_G, TEwGreen);
        end
        PH_EW_G:   s = enter_phase(s, PH_EW_Y, TYellow);
        PH_EW_Y: begin
          if (ns_turn_waiting) begin
            s = enter_phase(s, PH_NSLT_G, s.night ? TNsTurnNight : TNsTurnDay);
          end else begin
            s = cycle_end(s, daylight, ns_walk_secs);
          end
        end
        PH_NSLT_G: s = enter_phase(s, PH_NSLT_Y, TYellow);
        PH_NSLT_Y: s = cycle_end(s, daylight, ns_walk_secs);
        default:   s = start_cycle(s, daylight, ns_walk_secs);
      endcase
    end

    o.ns_color      = COLOR_RED;
    o.ns_turn_color = COLOR_RED;
    o.ew_color      = COLOR_RED;
    o.ew_turn_color = COLOR_RED;
    o.seconds_left  = '0;
    o.beep          = 1'b0;
    o.flashing      = 1'b0;
    c               = COLOR_RED;

    if (s.phase == PH_FLASH) begin
      c = s.flash_lit ? COLOR_RED : COLOR_OFF;
      o.ns_color      = c;
      o.ns_turn_color = c;
      o.ew_color      = c;
      o.ew_turn_color = c;
      o.flashing      = 1'b1;
      s.flash_lit     = !s.flash_lit;
    end else begin
      o.seconds_left = s.secs;
      case (s.phase)
        PH_NS_PED: begin
          o.ns_color     = COLOR_GREEN;
          o.beep         = 1'b1;
          o.seconds_left = s.secs - secs_t'(1);
        end
        PH_NS_G:   o.ns_color      = COLOR_GREEN;
        PH_NS_Y:   o.ns_color      = COLOR_YELLOW;
        PH_EWLT_G: o.ew_turn_color = COLOR_GREEN;
        PH_EWLT_Y: o.ew_turn_color = COLOR_YELLOW;
        PH_EW_PED: begin
          o.ew_color     = COLOR_GREEN;
          o.beep         = 1'b1;
          o.seconds_left = s.secs - secs_t'(1);
        end
        PH_EW_G:   o.ew_color      = COLOR_GREEN;
        PH_EW_Y:   o.ew_color      = COLOR_YELLOW;
        PH_NSLT_G: o.ns_turn_color = COLOR_GREEN;
        PH_NSLT_Y: o.ns_turn_color = COLOR_YELLOW;
        default:   ;
      endcase
      if (s.secs != '0) begin
        s.secs = s.secs - secs_t'(1);
      end
    end

    // Presses of this tick are latched after the outputs are decided.
    if (ns_walk_press) s.ns_walk = 1'b1;
    if (ew_walk_press) s.ew_walk = 1'b1;
    if (flash_press)   s.flash_pending = 1'b1;

    state_nxt = s;
    result    = o;
  end

endmodule

/* hw/rtl/iss_checker.sv */
// ----------------------------------------------------------------------------
// iss_checker
// Port-level assertions for the intersection signal sequencer.
// ----------------------------------------------------------------------------
module iss_checker
  import iss_pkg::*;
(
  input logic            clk,
  input logic            rst_n,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic [1:0]      out_ns_color,
  input logic [1:0]      out_ns_turn_color,
  input logic [1:0]      out_ew_color,
  input logic [1:0]      out_ew_turn_color,
  input logic [SecW-1:0] out_seconds_left,
  input logic            out_beep,
  input logic            out_flashing
);

  // A stalled result word holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_ns_color) &&
      $stable(out_ew_color) && $stable(out_seconds_left) && $stable(out_flashing))
    else $error("output word changed while stalled");

  // The block stalls its input only while a result is held back.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a held result");

  // Flashing shows four equal reds or four dark lamps, no count, no beep.
  a_flash: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_flashing |->
      out_ns_color == out_ew_color && out_ns_color == out_ns_turn_color &&
      out_ns_color == out_ew_turn_color &&
      (out_ns_color == COLOR_RED || out_ns_color == COLOR_OFF) &&
      out_seconds_left == '0 && !out_beep)
    else $error("bad flashing word");

  // The buzzer only sounds with one through direction green and all else red.
  a_beep: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_beep |-> !out_flashing &&
      out_ns_turn_color == COLOR_RED && out_ew_turn_color == COLOR_RED &&
      ((out_ns_color == COLOR_GREEN && out_ew_color == COLOR_RED) ||
       (out_ew_color == COLOR_GREEN && out_ns_color == COLOR_RED)))
    else $error("beep with conflicting lamps");

endmodule

bind intersection_signal_sequencer iss_checker u_iss_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_ns_color      (out_ns_color),
  .out_ns_turn_color (out_ns_turn_color),
  .out_ew_color      (out_ew_color),
  .out_ew_turn_color (out_ew_turn_color),
  .out_seconds_left  (out_seconds_left),
  .out_beep          (out_beep),
  .out_flashing      (out_flashing)
);
